@@ rtl/pds_pkg.sv @@
package pds_pkg;

  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned CountW        = 16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PLUS_TO_SPACE = 2'd0,
    CFG_MAX_OUTPUT    = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_e;

  typedef struct packed {
    logic              plus_to_space;
    logic [CountW-1:0] max_output;
  } cfg_t;

  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic       trunc0;
    logic [7:0] byte1;
    logic       trunc1;
  } job_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  function automatic logic is_dropped(input logic [7:0] v);
    return (v == CH_DEL) || ((v < CH_SPACE) && !(v inside {[8'h09:8'h0D]}));
  endfunction

endpackage

@@ rtl/pds_if.sv @@
interface pds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface pds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       truncated;

  modport source (output valid, output out_byte, output last_of_run, output truncated,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input truncated,
                  output ready);
endinterface

@@ rtl/pds_front.sv @@
module pds_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pds_in_if.sink        in_i,
  input  pds_pkg::cfg_t cfg_i,
  input  logic          full_i,
  output logic          push_o,
  output pds_pkg::job_t job_o
);
  import pds_pkg::*;

  held_e             held_q, held_d;
  logic [7:0]        digit_q, digit_d;
  logic              stop_q, stop_d;
  logic [CountW-1:0] em_q, em_d;

  logic              fire;
  logic              active;
  logic [CountW-1:0] em1, em2;
  logic [7:0]        b, pb, v;
  logic [4:0]        hv_hi, hv_lo;
  logic              e0, e1;
  logic [7:0]        b0, b1;

  assign in_i.ready = !full_i;
  assign fire       = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign pb         = (cfg_i.plus_to_space && (b == CH_PLUS)) ? CH_SPACE : b;
  assign em1        = em_q + CountW'(1);
  assign em2        = em_q + CountW'(2);
  assign active     = !stop_q && (em_q < cfg_i.max_output);
  assign hv_hi      = hex_val(digit_q);
  assign hv_lo      = hex_val(b);
  assign v          = {hv_hi[3:0], hv_lo[3:0]};

  always_comb begin
    held_d  = held_q;
    digit_d = digit_q;
    stop_d  = stop_q;
    e0      = 1'b0;
    e1      = 1'b0;
    b0      = pb;
    b1      = pb;
    if (active) begin
      case (held_q)
        HELD_PCT: begin
          if (in_i.is_last) begin
            held_d = HELD_NONE;
            e0     = 1'b1;
            b0     = CH_PCT;
            e1     = (em1 < cfg_i.max_output) && (b != CH_NUL);
          end else begin
            digit_d = b;
            held_d  = HELD_DIGIT;
          end
        end
        HELD_DIGIT: begin
          held_d = HELD_NONE;
          if (hv_hi[4] && hv_lo[4]) begin
            e0 = !is_dropped(v);
            b0 = v;
          end else begin
            e0 = 1'b1;
            b0 = CH_PCT;
          end
        end
        default: begin
          held_d = HELD_NONE;
          if (b == CH_PCT) begin
            if (in_i.is_last) begin
              e0 = 1'b1;
              b0 = CH_PCT;
            end else begin
              held_d = HELD_PCT;
            end
          end else if (b == CH_NUL) begin
            stop_d = 1'b1;
          end else begin
            e0 = 1'b1;
          end
        end
      endcase
    end
    if (e1) begin
      em_d = em2;
    end else if (e0) begin
      em_d = em1;
    end else begin
      em_d = em_q;
    end
    if (in_i.is_last) begin
      held_d  = HELD_NONE;
      digit_d = '0;
      stop_d  = 1'b0;
      em_d    = '0;
    end
  end

  always_comb begin
    push_o       = fire && e0;
    job_o.two    = e1;
    job_o.byte0  = b0;
    job_o.trunc0 = (em1 == cfg_i.max_output);
    job_o.byte1  = b1;
    job_o.trunc1 = (em2 == cfg_i.max_output);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= HELD_NONE;
      digit_q <= '0;
      stop_q  <= 1'b0;
      em_q    <= '0;
    end else if (fire) begin
      held_q  <= held_d;
      digit_q <= digit_d;
      stop_q  <= stop_d;
      em_q    <= em_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_i.is_last |=> (em_q == '0) && (held_q == HELD_NONE) && !stop_q)
    else $error("stream end left state behind");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("push into full queue");

endmodule

@@ rtl/pds_queue.sv @@
module pds_queue #(
  parameter int unsigned Depth = pds_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pds_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pds_pkg::job_t job_o
);
  import pds_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

@@ rtl/pds_back.sv @@
module pds_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  pds_pkg::job_t job_i,
  output logic          pop_o,
  pds_out_if.source     out_o
);
  import pds_pkg::*;

  logic phase_q, phase_d;
  logic fire;
  logic final_res;

  assign final_res         = phase_q || !job_i.two;
  assign out_o.valid       = valid_i;
  assign out_o.out_byte    = phase_q ? job_i.byte1 : job_i.byte0;
  assign out_o.truncated   = phase_q ? job_i.trunc1 : job_i.trunc0;
  assign out_o.last_of_run = final_res;
  assign fire              = valid_i && out_o.ready;
  assign pop_o             = fire && final_res;

  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      phase_d = !final_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

  a_phase_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> valid_i && job_i.two)
    else $error("second result without a two-result job");

endmodule

@@ rtl/percent_decode_stream.sv @@
// Channel   Dir  Payload                              Handshake
// in_i      in   in_byte[7:0], is_last                valid/ready
// out_o     out  out_byte[7:0], last_of_run, truncated valid/ready
// cfg       in   cfg_idx_i[1:0], cfg_data_i[15:0]      cfg_we_i, no stall
//
// One item accepted per cycle while the queue is not full; the front decides its results in that cycle.
// The output port moves one result per cycle while out_o.ready is high, so an item with two results holds it for both.
// Items wait in a queue of QueueDepth entries; in_i.ready drops only when it is full.
// rst_ni clears decode state, queue and config (plus_to_space 0, max_output 65535).
module percent_decode_stream #(
  parameter int unsigned QueueDepth = pds_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pds_in_if.sink                       in_i,
  pds_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [pds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pds_pkg::CfgDataW-1:0] cfg_data_i
);
  import pds_pkg::*;

  cfg_t cfg_q;
  logic full, push, pop, q_valid;
  job_t job_in, job_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plus_to_space <= 1'b0;
      cfg_q.max_output    <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PLUS_TO_SPACE: cfg_q.plus_to_space <= cfg_data_i[0];
        CFG_MAX_OUTPUT:    cfg_q.max_output    <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  pds_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  pds_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (job_head)
  );

  pds_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .job_i   (job_head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
